// File: rtl/core/ptb_pkg.sv
// shared types and codes for the pausable timer bank
package ptb_pkg;

   localparam int ACTION_W = 3;
   localparam int ID_W     = 3;
   localparam int COUNT_W  = 32;
   localparam int RUN_W    = 2;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_START  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_PAUSE  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_RESUME = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_SET    = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_READ   = 3'd5;

   // timer run states
   localparam logic [RUN_W-1:0] RUN_STOPPED = 2'd0;
   localparam logic [RUN_W-1:0] RUN_RUNNING = 2'd1;
   localparam logic [RUN_W-1:0] RUN_PAUSED  = 2'd2;

   // one stored timer entry
   typedef struct packed {
      logic [RUN_W-1:0]   run;
      logic [COUNT_W-1:0] count;
   } entry_type;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_LOOK,
      S_APPLY,
      S_EMIT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic walk_step;
      logic id_read;
      logic apply;
      logic emit;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic walk_busy;
      logic out_free;
   } status_type;

endpackage

// File: rtl/core/ptb_ram.sv
// generic single write port ram with registered read
module ptb_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/ptb_ctrl.sv
// controller state machine for the timer bank
module ptb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ptb_pkg::status_type status,
   output ptb_pkg::cmd_type    cmd
);

   ptb_pkg::state_type state_ff;
   ptb_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptb_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptb_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = ptb_pkg::S_WALK;
            end
         end
         ptb_pkg::S_WALK: begin
            if (!status.walk_busy) begin
               state_in = ptb_pkg::S_LOOK;
            end
         end
         ptb_pkg::S_LOOK: begin
            state_in = ptb_pkg::S_APPLY;
         end
         ptb_pkg::S_APPLY: begin
            state_in = ptb_pkg::S_EMIT;
         end
         ptb_pkg::S_EMIT: begin
            if (status.out_free) begin
               state_in = ptb_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ptb_pkg::S_IDLE;
         end
      endcase
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ptb_pkg::S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ptb_pkg::S_WALK: begin
            cmd.walk_step = 1'b1;
         end
         ptb_pkg::S_LOOK: begin
            cmd.id_read = 1'b1;
         end
         ptb_pkg::S_APPLY: begin
            cmd.apply = 1'b1;
         end
         ptb_pkg::S_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: rtl/core/ptb_dp.sv
// datapath: timer store, tick walk, command update and result register
module ptb_dp #(
   parameter int NUM_TIMERS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ptb_pkg::cmd_type                     cmd,
   output ptb_pkg::status_type                  status,
   input  logic [ptb_pkg::ACTION_W-1:0]         req_action,
   input  logic [ptb_pkg::ID_W-1:0]             req_timer_id,
   input  logic [ptb_pkg::COUNT_W-1:0]          req_new_count,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ptb_pkg::COUNT_W-1:0]          rsp_count_out,
   output logic [ptb_pkg::RUN_W-1:0]            rsp_run_state
);

   localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CW = $clog2(NUM_TIMERS + 1);
   localparam int EW = $bits(ptb_pkg::entry_type);

   // captured command
   logic [ptb_pkg::ACTION_W-1:0] act_ff;
   logic [ptb_pkg::ID_W-1:0]     id_ff;
   logic [ptb_pkg::COUNT_W-1:0]  new_ff;
   logic                         id_ok_ff;

   // tick walk
   logic [CW-1:0] walk_ff, walk_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_addr_ff;
   logic          walk_done;

   // entries that hold a written value; others read as zero and stopped
   logic [NUM_TIMERS-1:0] valid_ff;

   // result and output registers
   ptb_pkg::entry_type res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ptb_pkg::entry_type rsp_ff;

   // ram ports
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr, id_addr;
   logic [EW-1:0] wr_data, rd_data;

   ptb_pkg::entry_type walk_cur, id_cur, id_new;
   logic               walk_inc;

   ptb_ram #(
      .WIDTH (EW),
      .DEPTH (NUM_TIMERS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign id_addr   = AW'(id_ff);
   assign walk_done = (walk_ff == CW'(NUM_TIMERS));

   // command capture on input transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff   <= req_action;
         id_ff    <= req_timer_id;
         new_ff   <= req_new_count;
         id_ok_ff <= (32'(req_timer_id) < NUM_TIMERS);
      end
   end

   // walk counter: a tick visits every timer, other actions skip the walk
   always_comb begin
      walk_in = walk_ff;
      pend_in = 1'b0;
      if (cmd.load) begin
         walk_in = (req_action == ptb_pkg::ACT_TICK) ? '0 : CW'(NUM_TIMERS);
      end else if (cmd.walk_step && !walk_done) begin
         walk_in = walk_ff + 1'b1;
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff <= CW'(NUM_TIMERS);
         pend_ff <= 1'b0;
      end else begin
         walk_ff <= walk_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_in) begin
         pend_addr_ff <= walk_ff[AW-1:0];
      end
   end

   // read data of the walk read issued last cycle
   assign walk_cur = valid_ff[pend_addr_ff] ? ptb_pkg::entry_type'(rd_data) : '0;
   assign walk_inc = pend_ff && (walk_cur.run == ptb_pkg::RUN_RUNNING);

   // addressed entry and its update
   always_comb begin
      id_cur = (id_ok_ff && valid_ff[id_addr]) ? ptb_pkg::entry_type'(rd_data) : '0;
      id_new = id_cur;
      case (act_ff)
         ptb_pkg::ACT_START: begin
            id_new.count = '0;
            id_new.run   = ptb_pkg::RUN_RUNNING;
         end
         ptb_pkg::ACT_PAUSE: begin
            if (id_cur.run == ptb_pkg::RUN_RUNNING) begin
               id_new.run = ptb_pkg::RUN_PAUSED;
            end
         end
         ptb_pkg::ACT_RESUME: begin
            if (id_cur.run == ptb_pkg::RUN_PAUSED) begin
               id_new.run = ptb_pkg::RUN_RUNNING;
            end
         end
         ptb_pkg::ACT_SET: begin
            id_new.count = new_ff;
         end
         default: begin
            id_new = id_cur;
         end
      endcase
   end

   // ram access mux
   always_comb begin
      rd_en   = (cmd.walk_step && !walk_done) || (cmd.id_read && id_ok_ff);
      rd_addr = cmd.id_read ? id_addr : walk_ff[AW-1:0];
      wr_en   = 1'b0;
      wr_addr = pend_addr_ff;
      wr_data = EW'(walk_cur);
      if (walk_inc) begin
         wr_en   = 1'b1;
         wr_data = EW'({walk_cur.run, walk_cur.count + 1'b1});
      end else if (cmd.apply && id_ok_ff) begin
         wr_en   = 1'b1;
         wr_addr = id_addr;
         wr_data = EW'(id_new);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // held result; an unknown timer reports zero
   assign res_in = id_ok_ff ? id_new : '0;

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         res_ff <= res_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= res_ff;
      end
   end

   assign status.walk_busy = !walk_done || pend_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_count_out = rsp_ff.count;
   assign rsp_run_state = rsp_ff.run;

endmodule

// File: rtl/core/pausable_timer_bank_core.sv
// top level of the pausable timer bank
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_action, req_timer_id, req_new_count
//   rsp      out  rsp_valid/rsp_stall  rsp_count_out, rsp_run_state
//
// a command (start, pause, resume, set, read) passes the walk, look, apply and emit
// states before the next free input slot; a tick also walks the bank, since the walk reads one
// timer per cycle, writes it back in the following cycle and waits for the last write-back.
// reset clears the per-timer valid bits at once, so no clearing pass is run.
// the input is stalled while an item is in work; a stalled output holds
// its result and the block waits for it to be taken before emitting the next result.
module pausable_timer_bank_core #(
   parameter int NUM_TIMERS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [ptb_pkg::ACTION_W-1:0] req_action,
   input  logic [ptb_pkg::ID_W-1:0]     req_timer_id,
   input  logic [ptb_pkg::COUNT_W-1:0]  req_new_count,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ptb_pkg::COUNT_W-1:0]  rsp_count_out,
   output logic [ptb_pkg::RUN_W-1:0]    rsp_run_state
);

   ptb_pkg::cmd_type    cmd;
   ptb_pkg::status_type status;

   // sequencing
   ptb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // timer store and result path
   ptb_dp #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_action    (req_action),
      .req_timer_id  (req_timer_id),
      .req_new_count (req_new_count),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_count_out (rsp_count_out),
      .rsp_run_state (rsp_run_state)
   );

endmodule

// File: rtl/core/ptb_checker.sv
// port-level checks for the timer bank, bound to the top level
module ptb_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [ptb_pkg::ACTION_W-1:0] req_action,
   input logic [ptb_pkg::ID_W-1:0]     req_timer_id,
   input logic [ptb_pkg::COUNT_W-1:0]  req_new_count,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [ptb_pkg::COUNT_W-1:0]  rsp_count_out,
   input logic [ptb_pkg::RUN_W-1:0]    rsp_run_state
);

   // one item in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again right after a transfer");

   // a result only appears while an item is in work
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared with no item in work");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_count_out)
         && $stable(rsp_run_state))
      else $error("stalled result changed");

   // reported state is a real run state
   a_run_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_run_state == ptb_pkg::RUN_STOPPED)
         || (rsp_run_state == ptb_pkg::RUN_RUNNING)
         || (rsp_run_state == ptb_pkg::RUN_PAUSED))
      else $error("bad run state reported");

endmodule

bind pausable_timer_bank_core ptb_checker u_checker (.*);

// File: tb/sv/pausable_timer_bank_checker.sv
// checker for the pausable timer bank: predicts each reading and compares it
`timescale 1ns / 1ps
module pausable_timer_bank_checker #(
   parameter int NUM_TIMERS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [ptb_pkg::ACTION_W-1:0] req_action,
   input  logic [ptb_pkg::ID_W-1:0]     req_timer_id,
   input  logic [ptb_pkg::COUNT_W-1:0]  req_new_count,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [ptb_pkg::COUNT_W-1:0]  rsp_count_out,
   input  logic [ptb_pkg::RUN_W-1:0]    rsp_run_state,
   output int                           mismatch_count,
   output int                           readings_pending
);

   // shadow copy of the timer bank
   logic [ptb_pkg::COUNT_W-1:0] shadow_count [NUM_TIMERS];
   logic [ptb_pkg::RUN_W-1:0]   shadow_run   [NUM_TIMERS];

   // readings still owed by the block, oldest first
   ptb_pkg::entry_type expected_readings [$];

   int bad_results   = 0;
   int owed_readings = 0;

   assign mismatch_count   = bad_results;
   assign readings_pending = owed_readings;

   // apply one action to the shadow bank and return the addressed timer's reading
   function automatic ptb_pkg::entry_type timer_bank_update(
      input logic [ptb_pkg::ACTION_W-1:0] action,
      input logic [ptb_pkg::ID_W-1:0]     id,
      input logic [ptb_pkg::COUNT_W-1:0]  value
   );
      ptb_pkg::entry_type reading;
      reading = '0;
      if (action == ptb_pkg::ACT_TICK) begin
         for (int k = 0; k < NUM_TIMERS; k++) begin
            if (shadow_run[k] == ptb_pkg::RUN_RUNNING)
               shadow_count[k] = shadow_count[k] + 1'b1;
         end
      end else if (id < NUM_TIMERS) begin
         case (action)
            ptb_pkg::ACT_START: begin
               shadow_count[id] = '0;
               shadow_run[id]   = ptb_pkg::RUN_RUNNING;
            end
            ptb_pkg::ACT_PAUSE: begin
               if (shadow_run[id] == ptb_pkg::RUN_RUNNING)
                  shadow_run[id] = ptb_pkg::RUN_PAUSED;
            end
            ptb_pkg::ACT_RESUME: begin
               if (shadow_run[id] == ptb_pkg::RUN_PAUSED)
                  shadow_run[id] = ptb_pkg::RUN_RUNNING;
            end
            ptb_pkg::ACT_SET: begin
               shadow_count[id] = value;
            end
            default: begin
            end
         endcase
      end
      // a timer number outside the bank reads as zero
      if (id < NUM_TIMERS) begin
         reading.count = shadow_count[id];
         reading.run   = shadow_run[id];
      end
      return reading;
   endfunction

   // count a failure, print only the first few
   task automatic report_failure(input string what, input ptb_pkg::entry_type want);
      bad_results++;
      if (bad_results <= 10)
         $display("%0t timer bank %s: expected count %h state %0d, got count %h state %0d",
                  $time, what, want.count, want.run, rsp_count_out, rsp_run_state);
   endtask

   // retire results first, then predict the request taken on the same edge
   always @(posedge clock) begin
      ptb_pkg::entry_type want;
      if (reset) begin
         for (int k = 0; k < NUM_TIMERS; k++) begin
            shadow_count[k] = '0;
            shadow_run[k]   = ptb_pkg::RUN_STOPPED;
         end
         expected_readings.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               report_failure("result with nothing owed", '0);
            end else begin
               want = expected_readings.pop_front();
               if (want.count !== rsp_count_out || want.run !== rsp_run_state)
                  report_failure("reading differs", want);
            end
         end
         if (req_valid && !req_stall)
            expected_readings.push_back(
               timer_bank_update(req_action, req_timer_id, req_new_count));
      end
      owed_readings = expected_readings.size();
   end

endmodule

// File: tb/sv/pausable_timer_bank_core_test.sv
// top of the pausable timer bank testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module pausable_timer_bank_core_test;

   localparam int NUM_TIMERS   = 8;
   localparam int RANDOM_ITEMS = 2000;

   // action codes the block treats as a read
   localparam logic [ptb_pkg::ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [ptb_pkg::ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

   bit                           clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [ptb_pkg::ACTION_W-1:0] req_action;
   logic [ptb_pkg::ID_W-1:0]     req_timer_id;
   logic [ptb_pkg::COUNT_W-1:0]  req_new_count;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [ptb_pkg::COUNT_W-1:0]  rsp_count_out;
   logic [ptb_pkg::RUN_W-1:0]    rsp_run_state;

   int mismatch_count;
   int readings_pending;

   bit no_idle    = 1'b0;
   bit rsp_taken  = 1'b1;
   int stall_hold = 0;

   pausable_timer_bank_core #(
      .NUM_TIMERS(NUM_TIMERS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_timer_id  (req_timer_id),
      .req_new_count (req_new_count),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_count_out (rsp_count_out),
      .rsp_run_state (rsp_run_state)
   );

   pausable_timer_bank_checker #(
      .NUM_TIMERS(NUM_TIMERS)
   ) bank_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_timer_id     (req_timer_id),
      .req_new_count    (req_new_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_count_out    (rsp_count_out),
      .rsp_run_state    (rsp_run_state),
      .mismatch_count   (mismatch_count),
      .readings_pending (readings_pending)
   );

   // 100 MHz clock
   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #10_000_000;
      $display("pausable_timer_bank_core: mismatch");
      $finish;
   end

   // note each result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         rsp_taken = 1'b1;
   end

   // result side stall: a fresh hold for every result, counted while it is shown
   always @(negedge clock) begin
      if (rsp_taken) begin
         stall_hold = no_idle ? 0 : $urandom_range(0, 5);
         rsp_taken  = 1'b0;
      end
      rsp_stall = (stall_hold > 0);
      if (rsp_valid && stall_hold > 0)
         stall_hold--;
   end

   // present one item after a random gap and wait for its transfer
   task automatic send_command(
      input logic [ptb_pkg::ACTION_W-1:0] action,
      input logic [ptb_pkg::ID_W-1:0]     id,
      input logic [ptb_pkg::COUNT_W-1:0]  value
   );
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid     = 1'b1;
      req_action    = action;
      req_timer_id  = id;
      req_new_count = value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      int                           roll;
      logic [ptb_pkg::ACTION_W-1:0] action;
      logic [ptb_pkg::COUNT_W-1:0]  value;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_action    = ptb_pkg::ACT_READ;
      req_timer_id  = '0;
      req_new_count = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset state, pause and resume rules, wrap, spare codes
      send_command(ptb_pkg::ACT_READ,   3'd0, 32'h0000_0000);
      send_command(ptb_pkg::ACT_START,  3'd0, 32'hFFFF_FFFF);
      send_command(ptb_pkg::ACT_TICK,   3'd0, 32'h0000_0000);
      send_command(ptb_pkg::ACT_TICK,   3'd7, 32'hFFFF_FFFF);
      send_command(ptb_pkg::ACT_PAUSE,  3'd0, 32'h0000_0000);
      send_command(ptb_pkg::ACT_TICK,   3'd0, 32'h0000_0000);
      send_command(ptb_pkg::ACT_PAUSE,  3'd0, 32'h0000_0000);
      send_command(ptb_pkg::ACT_RESUME, 3'd0, 32'h0000_0000);
      send_command(ptb_pkg::ACT_RESUME, 3'd0, 32'h0000_0000);
      send_command(ptb_pkg::ACT_SET,    3'd0, 32'hFFFF_FFFF);
      send_command(ptb_pkg::ACT_TICK,   3'd0, 32'h0000_0000);
      send_command(ptb_pkg::ACT_SET,    3'd7, 32'hFFFF_FFFF);
      send_command(ptb_pkg::ACT_TICK,   3'd7, 32'h0000_0000);
      send_command(ptb_pkg::ACT_START,  3'd7, 32'hFFFF_FFFF);
      send_command(ptb_pkg::ACT_SET,    3'd7, 32'hFFFF_FFFE);
      send_command(ptb_pkg::ACT_TICK,   3'd7, 32'h0000_0000);
      send_command(ptb_pkg::ACT_TICK,   3'd7, 32'h0000_0000);
      send_command(ptb_pkg::ACT_PAUSE,  3'd3, 32'h0000_0000);
      send_command(ptb_pkg::ACT_RESUME, 3'd3, 32'h0000_0000);
      send_command(ACT_SPARE_6,         3'd0, 32'hFFFF_FFFF);
      send_command(ACT_SPARE_7,         3'd7, 32'hAAAA_5555);
      send_command(ptb_pkg::ACT_START,  3'd0, 32'h0000_0000);
      send_command(ptb_pkg::ACT_SET,    3'd5, 32'h0000_0000);
      send_command(ptb_pkg::ACT_READ,   3'd7, 32'h5555_AAAA);

      // random traffic, ticks frequent enough to carry counts through the wrap
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         no_idle = ((n / 250) % 4) == 3;
         roll = $urandom_range(0, 99);
         if (roll < 35)
            action = ptb_pkg::ACT_TICK;
         else if (roll < 45)
            action = ptb_pkg::ACT_START;
         else if (roll < 55)
            action = ptb_pkg::ACT_PAUSE;
         else if (roll < 65)
            action = ptb_pkg::ACT_RESUME;
         else if (roll < 78)
            action = ptb_pkg::ACT_SET;
         else if (roll < 94)
            action = ptb_pkg::ACT_READ;
         else if (roll < 97)
            action = ACT_SPARE_6;
         else
            action = ACT_SPARE_7;
         case ($urandom_range(0, 3))
            0: value = $urandom();
            1: value = 32'hFFFF_FFFF - $urandom_range(0, 15);
            2: value = $urandom_range(0, 255);
            default: value = $urandom();
         endcase
         send_command(action, ptb_pkg::ID_W'($urandom_range(0, 7)), value);
      end
      @(negedge clock);
      req_valid = 1'b0;

      // drain, then allow the longest walk to settle
      wait (readings_pending == 0);
      repeat (NUM_TIMERS + 10) @(posedge clock);
      if (mismatch_count == 0 && readings_pending == 0)
         $display("pausable_timer_bank_core: match");
      else
         $display("pausable_timer_bank_core: mismatch");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/ptb_pkg.sv
rtl/core/ptb_ram.sv
rtl/core/ptb_ctrl.sv
rtl/core/ptb_dp.sv
rtl/core/pausable_timer_bank_core.sv
rtl/core/ptb_checker.sv
tb/sv/pausable_timer_bank_checker.sv
tb/sv/pausable_timer_bank_core_test.sv
